>>> sv/aqss_pkg.sv
// Shared types, constants and tables for the autotile quarter source select block.
// Holds the quad pattern table, the per-quarter neighbour bit masks and the mask cleaning.
// No dependencies.
package aqss_pkg;

  localparam int unsigned TILE_W      = 8;
  localparam int unsigned TILE3_W     = 10;
  localparam int unsigned SHEET_W     = 13;
  localparam int unsigned FRAMES_W    = 12;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned FRAME_W     = 16;
  localparam int unsigned QTR_W       = 2;
  localparam int unsigned SRC_X_W     = 13;
  localparam int unsigned SRC_Y_W     = 9;
  localparam int unsigned CELL_W      = 4;
  localparam int unsigned NIB_W       = 4;
  localparam int unsigned MOD_STEPS   = FRAME_W / NIB_W;
  localparam int unsigned MOD_CNT_W   = $clog2(MOD_STEPS);
  localparam int unsigned DIV_STEPS   = SHEET_W;
  localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [TILE_W-1:0]   TILE_SIZE_RESET   = 8'd32;
  localparam logic [SHEET_W-1:0]  SHEET_WIDTH_RESET = 13'd96;
  localparam logic [FRAMES_W-1:0] FRAMES_RESET      = 12'd1;
  localparam logic [MASK_W-1:0]   EDGE_MASK         = 8'h0F;
  localparam logic [CELL_W-1:0]   INNER_CORNER_CELL = 4'd3;

  typedef enum logic [0:0] {
    REG_TILE_SIZE   = 1'b0,
    REG_SHEET_WIDTH = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [TILE_W-1:0]   tile_size;
    logic [TILE3_W-1:0]  tile3;
    logic [FRAMES_W-1:0] frame_count;
    logic                busy;
  } aqss_cfg_t;

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [SRC_X_W-1:0] xoff;
  } aqss_entry_t;

  localparam logic [CELL_W-1:0] QUAD_PATTERN [16][4] = '{
    '{4'd1,  4'd1,  4'd1,  4'd1},  '{4'd10, 4'd12, 4'd10, 4'd12},
    '{4'd4,  4'd4,  4'd10, 4'd10}, '{4'd10, 4'd10, 4'd10, 4'd10},
    '{4'd4,  4'd6,  4'd4,  4'd6},  '{4'd7,  4'd9,  4'd7,  4'd9},
    '{4'd4,  4'd4,  4'd4,  4'd4},  '{4'd7,  4'd7,  4'd7,  4'd7},
    '{4'd6,  4'd6,  4'd12, 4'd12}, '{4'd12, 4'd12, 4'd12, 4'd12},
    '{4'd5,  4'd5,  4'd11, 4'd11}, '{4'd11, 4'd11, 4'd11, 4'd11},
    '{4'd6,  4'd6,  4'd6,  4'd6},  '{4'd9,  4'd9,  4'd9,  4'd9},
    '{4'd5,  4'd5,  4'd5,  4'd5},  '{4'd8,  4'd8,  4'd8,  4'd8}
  };

  // Edge A, edge B and diagonal mask bits of each quarter
  localparam logic [MASK_W-1:0] QTR_EDGE_A [4] = '{8'h01, 8'h01, 8'h04, 8'h04};
  localparam logic [MASK_W-1:0] QTR_EDGE_B [4] = '{8'h08, 8'h02, 8'h08, 8'h02};
  localparam logic [MASK_W-1:0] QTR_DIAG   [4] = '{8'h10, 8'h20, 8'h80, 8'h40};

  // Keep a diagonal only where both adjoining edges are set
  function automatic logic [MASK_W-1:0] clean_mask(input logic [MASK_W-1:0] m);
    logic [MASK_W-1:0] r;
    r = m & EDGE_MASK;
    for (int q = 0; q < 4; q++) begin
      if ((|(m & QTR_EDGE_A[q])) && (|(m & QTR_EDGE_B[q])) && (|(m & QTR_DIAG[q]))) begin
        r = r | QTR_DIAG[q];
      end
    end
    return r;
  endfunction

endpackage

>>> sv/autotile_quarter_source_select.sv
// Autotile quarter source select: turns a neighbour mask and an animation frame into the
// sheet coordinates of the four quarter tiles.
// Input channel item_valid_i/item_ready_o carries neighbour_mask_i and a signed
// frame_number_i. Each accepted item yields four results on result_valid_o/result_ready_i,
// quarters 0 to 3 in order, last_quarter_o marking the fourth.
// Configuration: cfg_we_i writes cfg_data_i to register cfg_index_i (0 tile size,
// 1 sheet width) at once. Each write starts the frame count divide (a load step and
// 13 divide steps), during which item_ready_o is low.
// Each item passes the modulo iteration stage, the fix-up and multiply stage, the queue,
// the quarter walker and the result register. The modulo unit retires four remainder bits
// a cycle unless stalled; it and the four-beat back end take a new item as each ends one.
// A 2-entry queue decouples the front end from the result side; a stalled receiver holds
// the registered result and back-pressure reaches item_ready_o once the queue is full.
// Reset: tile size 32, sheet width 96, frame count 1, all stages empty.
// Depends on aqss_pkg, aqss_cfg, aqss_front, aqss_queue and aqss_back.
module autotile_quarter_source_select (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [0:0]                    cfg_index_i,
  input  logic [aqss_pkg::SHEET_W-1:0]  cfg_data_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  logic [aqss_pkg::MASK_W-1:0]   neighbour_mask_i,
  input  logic signed [aqss_pkg::FRAME_W-1:0] frame_number_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [aqss_pkg::QTR_W-1:0]    quarter_index_o,
  output logic [aqss_pkg::SRC_X_W-1:0]  source_x_o,
  output logic [aqss_pkg::SRC_Y_W-1:0]  source_y_o,
  output logic                          last_quarter_o
);

  aqss_pkg::aqss_cfg_t   cfg;
  aqss_pkg::cfg_reg_e    cfg_index;
  logic                  fq_valid;
  logic                  fq_ready;
  aqss_pkg::aqss_entry_t fq_data;
  logic                  qb_valid;
  logic                  qb_ready;
  aqss_pkg::aqss_entry_t qb_data;

  assign cfg_index = aqss_pkg::cfg_reg_e'(cfg_index_i);

  aqss_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  aqss_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .item_valid_i     (item_valid_i),
    .item_ready_o     (item_ready_o),
    .neighbour_mask_i (neighbour_mask_i),
    .frame_number_i   (frame_number_i),
    .entry_valid_o    (fq_valid),
    .entry_ready_i    (fq_ready),
    .entry_o          (fq_data)
  );

  aqss_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_data_i  (fq_data),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_data_o   (qb_data)
  );

  aqss_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .entry_valid_i   (qb_valid),
    .entry_ready_o   (qb_ready),
    .entry_i         (qb_data),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .quarter_index_o (quarter_index_o),
    .source_x_o      (source_x_o),
    .source_y_o      (source_y_o),
    .last_quarter_o  (last_quarter_o)
  );

endmodule

>>> sv/aqss_cfg.sv
// Configuration registers and frame count unit of the autotile quarter source select block.
// Frame count is a restoring divide of sheet width by three tile widths, one bit per cycle.
// Depends on aqss_pkg.
module aqss_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  aqss_pkg::cfg_reg_e            cfg_index_i,
  input  logic [aqss_pkg::SHEET_W-1:0]  cfg_data_i,
  output aqss_pkg::aqss_cfg_t           cfg_o
);

  logic [aqss_pkg::TILE_W-1:0]    tile_q, tile_d;
  logic [aqss_pkg::SHEET_W-1:0]   sheet_q, sheet_d;
  logic [aqss_pkg::FRAMES_W-1:0]  frames_q, frames_d;
  logic                           busy_q, busy_d;
  logic                           load_q, load_d;
  logic [aqss_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [aqss_pkg::SHEET_W-1:0]   dq_q, dq_d;
  logic [aqss_pkg::TILE3_W-1:0]   drem_q, drem_d;

  logic [aqss_pkg::TILE3_W-1:0]   tile3;
  logic [aqss_pkg::TILE3_W:0]     trial;
  logic                           ge;
  logic [aqss_pkg::TILE3_W-1:0]   rem_next;
  logic [aqss_pkg::SHEET_W-1:0]   quo_final;
  logic                           step_last;

  assign tile3     = {2'b00, tile_q} + {1'b0, tile_q, 1'b0};
  assign trial     = {drem_q, dq_q[aqss_pkg::SHEET_W-1]};
  assign ge        = trial >= {1'b0, tile3};
  assign rem_next  = ge ? aqss_pkg::TILE3_W'(trial - {1'b0, tile3})
                        : trial[aqss_pkg::TILE3_W-1:0];
  assign quo_final = {dq_q[aqss_pkg::SHEET_W-2:0], ge};
  assign step_last = cnt_q == aqss_pkg::DIV_CNT_W'(aqss_pkg::DIV_STEPS - 1);

  always_comb begin
    tile_d   = tile_q;
    sheet_d  = sheet_q;
    frames_d = frames_q;
    busy_d   = busy_q;
    load_d   = load_q;
    cnt_d    = cnt_q;
    dq_d     = dq_q;
    drem_d   = drem_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        aqss_pkg::REG_TILE_SIZE:   tile_d  = cfg_data_i[aqss_pkg::TILE_W-1:0];
        aqss_pkg::REG_SHEET_WIDTH: sheet_d = cfg_data_i;
        default: ;
      endcase
      // restart the divide on any write
      busy_d = 1'b1;
      load_d = 1'b1;
    end else if (busy_q && load_q) begin
      dq_d   = sheet_q;
      drem_d = '0;
      cnt_d  = '0;
      load_d = 1'b0;
    end else if (busy_q) begin
      dq_d   = quo_final;
      drem_d = rem_next;
      cnt_d  = cnt_q + 1'b1;
      if (step_last) begin
        busy_d = 1'b0;
        if ((tile_q == '0) || (sheet_q == '0) || (quo_final == '0)) begin
          frames_d = aqss_pkg::FRAMES_RESET;
        end else begin
          frames_d = quo_final[aqss_pkg::FRAMES_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_q   <= aqss_pkg::TILE_SIZE_RESET;
      sheet_q  <= aqss_pkg::SHEET_WIDTH_RESET;
      frames_q <= aqss_pkg::FRAMES_RESET;
      busy_q   <= 1'b0;
      load_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      tile_q   <= tile_d;
      sheet_q  <= sheet_d;
      frames_q <= frames_d;
      busy_q   <= busy_d;
      load_q   <= load_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q   <= dq_d;
    drem_q <= drem_d;
  end

  assign cfg_o.tile_size   = tile_q;
  assign cfg_o.tile3       = tile3;
  assign cfg_o.frame_count = frames_q;
  assign cfg_o.busy        = busy_q;

endmodule

>>> sv/aqss_front.sv
// Front end: accepts items, cleans the mask and reduces the frame modulo the frame count.
// Four remainder bits per cycle in the iteration stage, which holds its last step while the
// next stage is stalled, then a fix-up and x offset multiply stage. Depends on aqss_pkg.
module aqss_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aqss_pkg::aqss_cfg_t           cfg_i,
  input  logic                          item_valid_i,
  output logic                          item_ready_o,
  input  logic [aqss_pkg::MASK_W-1:0]   neighbour_mask_i,
  input  logic [aqss_pkg::FRAME_W-1:0]  frame_number_i,
  output logic                          entry_valid_o,
  input  logic                          entry_ready_i,
  output aqss_pkg::aqss_entry_t         entry_o
);

  localparam int unsigned FW = aqss_pkg::FRAMES_W;

  function automatic logic [FW-1:0] mod_step(input logic [FW-1:0] rem,
                                             input logic [aqss_pkg::NIB_W-1:0] nib,
                                             input logic [FW-1:0] n);
    logic [FW-1:0] r;
    logic [FW:0]   t;
    r = rem;
    for (int i = aqss_pkg::NIB_W - 1; i >= 0; i--) begin
      t = {r, nib[i]};
      if (t >= {1'b0, n}) begin
        r = FW'(t - {1'b0, n});
      end else begin
        r = t[FW-1:0];
      end
    end
    return r;
  endfunction

  // iteration stage
  logic                            a_valid_q, a_valid_d;
  logic [aqss_pkg::MOD_CNT_W-1:0]  a_cnt_q, a_cnt_d;
  logic [aqss_pkg::FRAME_W-1:0]    a_div_q;
  logic [FW-1:0]                   a_rem_q;
  logic                            a_neg_q;
  logic [aqss_pkg::MASK_W-1:0]     a_mask_q;
  // fix-up and multiply stage
  logic                            b_valid_q, b_valid_d;
  logic [FW-1:0]                   b_rem_q;
  logic                            b_neg_q;
  logic [aqss_pkg::MASK_W-1:0]     b_mask_q;

  logic [FW-1:0]                   step_rem;
  logic                            a_last;
  logic                            b_take;
  logic                            a_done;
  logic                            accept;
  logic [aqss_pkg::FRAME_W-1:0]    frame_abs;
  logic [FW-1:0]                   fmod;
  logic [FW+aqss_pkg::TILE3_W-1:0] xoff_full;

  assign step_rem  = mod_step(a_rem_q, a_div_q[aqss_pkg::FRAME_W-1 -: aqss_pkg::NIB_W],
                              cfg_i.frame_count);
  assign a_last    = a_cnt_q == aqss_pkg::MOD_CNT_W'(aqss_pkg::MOD_STEPS - 1);
  assign b_take    = !b_valid_q || entry_ready_i;
  assign a_done    = a_valid_q && a_last && b_take;
  assign item_ready_o = (!a_valid_q || a_done) && !cfg_i.busy;
  assign accept    = item_valid_i && item_ready_o;
  assign frame_abs = frame_number_i[aqss_pkg::FRAME_W-1] ? (~frame_number_i + 1'b1)
                                                         : frame_number_i;

  always_comb begin
    a_valid_d = a_valid_q;
    a_cnt_d   = a_cnt_q;
    if (accept) begin
      a_valid_d = 1'b1;
      a_cnt_d   = '0;
    end else if (a_done) begin
      a_valid_d = 1'b0;
    end else if (a_valid_q && !a_last) begin
      a_cnt_d = a_cnt_q + 1'b1;
    end
    if (a_done) begin
      b_valid_d = 1'b1;
    end else if (entry_ready_i) begin
      b_valid_d = 1'b0;
    end else begin
      b_valid_d = b_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      a_cnt_q   <= '0;
      b_valid_q <= 1'b0;
    end else begin
      a_valid_q <= a_valid_d;
      a_cnt_q   <= a_cnt_d;
      b_valid_q <= b_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_div_q  <= frame_abs;
      a_rem_q  <= '0;
      a_neg_q  <= frame_number_i[aqss_pkg::FRAME_W-1];
      a_mask_q <= aqss_pkg::clean_mask(neighbour_mask_i);
    end else if (a_valid_q && !a_last) begin
      a_div_q <= a_div_q << aqss_pkg::NIB_W;
      a_rem_q <= step_rem;
    end
    if (a_done) begin
      b_rem_q  <= step_rem;
      b_neg_q  <= a_neg_q;
      b_mask_q <= a_mask_q;
    end
  end

  // negative frames wrap to the non-negative residue
  assign fmod      = (b_neg_q && (b_rem_q != '0)) ? (cfg_i.frame_count - b_rem_q) : b_rem_q;
  assign xoff_full = fmod * cfg_i.tile3;

  assign entry_valid_o = b_valid_q;
  assign entry_o.mask  = b_mask_q;
  assign entry_o.xoff  = xoff_full[aqss_pkg::SRC_X_W-1:0];

endmodule

>>> sv/aqss_queue.sv
// Short queue between the front and back ends of the autotile quarter source select block.
// Register-based, depth set by the package. Depends on aqss_pkg.
module aqss_queue (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_valid_i,
  output logic                  push_ready_o,
  input  aqss_pkg::aqss_entry_t push_data_i,
  output logic                  pop_valid_o,
  input  logic                  pop_ready_i,
  output aqss_pkg::aqss_entry_t pop_data_o
);

  aqss_pkg::aqss_entry_t           slots_q [aqss_pkg::QUEUE_DEPTH];
  logic [aqss_pkg::QPTR_W-1:0]     wr_ptr_q, wr_ptr_d;
  logic [aqss_pkg::QPTR_W-1:0]     rd_ptr_q, rd_ptr_d;
  logic [aqss_pkg::QCNT_W-1:0]     count_q, count_d;
  logic                            push;
  logic                            pop;

  assign push_ready_o = count_q != aqss_pkg::QCNT_W'(aqss_pkg::QUEUE_DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = slots_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == aqss_pkg::QPTR_W'(aqss_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == aqss_pkg::QPTR_W'(aqss_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slots_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

>>> sv/aqss_back.sv
// Back end: walks the four quarters of a queued item and drives the registered result channel.
// Uses the quad pattern table and quarter bit masks. Depends on aqss_pkg.
module aqss_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  aqss_pkg::aqss_cfg_t           cfg_i,
  input  logic                          entry_valid_i,
  output logic                          entry_ready_o,
  input  aqss_pkg::aqss_entry_t         entry_i,
  output logic                          result_valid_o,
  input  logic                          result_ready_i,
  output logic [aqss_pkg::QTR_W-1:0]    quarter_index_o,
  output logic [aqss_pkg::SRC_X_W-1:0]  source_x_o,
  output logic [aqss_pkg::SRC_Y_W-1:0]  source_y_o,
  output logic                          last_quarter_o
);

  localparam int unsigned SPAN_W = aqss_pkg::TILE_W + 2;

  logic                            cur_valid_q, cur_valid_d;
  aqss_pkg::aqss_entry_t           cur_q;
  logic [aqss_pkg::QTR_W-1:0]      qidx_q, qidx_d;
  logic                            out_valid_q, out_valid_d;
  logic [aqss_pkg::QTR_W-1:0]      out_qidx_q;
  logic [aqss_pkg::SRC_X_W-1:0]    out_x_q;
  logic [aqss_pkg::SRC_Y_W-1:0]    out_y_q;
  logic                            out_last_q;

  logic                            adv;
  logic                            q_last;
  logic                            pop;
  logic                            inner;
  logic [aqss_pkg::CELL_W-1:0]     cell_num;
  logic [aqss_pkg::CELL_W-1:0]     c0;
  logic [1:0]                      row;
  logic [1:0]                      col;
  logic [aqss_pkg::TILE_W-2:0]     half;
  logic [SPAN_W-1:0]               col_px;
  logic [SPAN_W-1:0]               row_px;
  logic [aqss_pkg::SRC_X_W:0]      sx;
  logic [SPAN_W:0]                 sy;

  assign adv    = cur_valid_q && (!out_valid_q || result_ready_i);
  assign q_last = qidx_q == '1;
  assign pop    = entry_valid_i && entry_ready_o;
  assign entry_ready_o = !cur_valid_q || (adv && q_last);

  // cell of the current quarter, then its column and row on the sheet
  always_comb begin
    inner = (|(cur_q.mask & aqss_pkg::QTR_EDGE_A[qidx_q]))
         && (|(cur_q.mask & aqss_pkg::QTR_EDGE_B[qidx_q]))
         && !(|(cur_q.mask & aqss_pkg::QTR_DIAG[qidx_q]));
    cell_num = inner ? aqss_pkg::INNER_CORNER_CELL
                     : aqss_pkg::QUAD_PATTERN[cur_q.mask[3:0]][qidx_q];
    c0    = cell_num - 1'b1;
    if (c0 >= 4'd9) begin
      row = 2'd3;
    end else if (c0 >= 4'd6) begin
      row = 2'd2;
    end else if (c0 >= 4'd3) begin
      row = 2'd1;
    end else begin
      row = 2'd0;
    end
    col    = 2'(c0 - ({2'b00, row} + {1'b0, row, 1'b0}));
    half   = cfg_i.tile_size[aqss_pkg::TILE_W-1:1];
    col_px = col * cfg_i.tile_size;
    row_px = row * cfg_i.tile_size;
    sx     = {4'b0000, col_px} + (qidx_q[0] ? {7'b0000000, half} : '0) + {1'b0, cur_q.xoff};
    sy     = {1'b0, row_px} + (qidx_q[1] ? {4'b0000, half} : '0);
  end

  always_comb begin
    cur_valid_d = cur_valid_q;
    qidx_d      = qidx_q;
    if (pop) begin
      cur_valid_d = 1'b1;
      qidx_d      = '0;
    end else if (adv) begin
      qidx_d = qidx_q + 1'b1;
      if (q_last) begin
        cur_valid_d = 1'b0;
      end
    end
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      qidx_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      qidx_q      <= qidx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      cur_q <= entry_i;
    end
    if (adv) begin
      out_qidx_q <= qidx_q;
      out_x_q    <= sx[aqss_pkg::SRC_X_W-1:0];
      out_y_q    <= sy[aqss_pkg::SRC_Y_W-1:0];
      out_last_q <= q_last;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign quarter_index_o = out_qidx_q;
  assign source_x_o      = out_x_q;
  assign source_y_o      = out_y_q;
  assign last_quarter_o  = out_last_q;

endmodule

>>> tb/tb_top.sv
// Testbench for the autotile quarter source select block: drives mask and frame items,
// predicts the four quarter coordinates of each and checks every result transaction.
// Depends on aqss_pkg and autotile_quarter_source_select.
`timescale 1ns / 1ps

module tb_top;
  import aqss_pkg::*;

  localparam int QUIET_LIMIT     = 2000;
  localparam int PHASES          = 10;
  localparam int RANDOM_PER_SET  = 55;
  localparam int MAX_REPORTS     = 40;
  localparam int unsigned INNER_CELL = 3;

  // Cell numbers of the four quarters for each combination of edge bits
  localparam int unsigned QUAD_CELLS [16][4] = '{
    '{1, 1, 1, 1},     '{10, 12, 10, 12}, '{4, 4, 10, 10},   '{10, 10, 10, 10},
    '{4, 6, 4, 6},     '{7, 9, 7, 9},     '{4, 4, 4, 4},     '{7, 7, 7, 7},
    '{6, 6, 12, 12},   '{12, 12, 12, 12}, '{5, 5, 11, 11},   '{11, 11, 11, 11},
    '{6, 6, 6, 6},     '{9, 9, 9, 9},     '{5, 5, 5, 5},     '{8, 8, 8, 8}
  };
  // Mask bit positions of each quarter's edges A and B and its diagonal
  localparam int SIDE_A_BIT [4] = '{0, 0, 2, 2};
  localparam int SIDE_B_BIT [4] = '{3, 1, 3, 1};
  localparam int DIAG_BIT   [4] = '{4, 5, 7, 6};

  localparam int unsigned SET_TILE  [PHASES] = '{32, 16, 0, 255, 128, 1, 3, 0, 32, 128};
  localparam int unsigned SET_SHEET [PHASES] = '{96, 8191, 8191, 8191, 0, 8191, 200, 0, 96,
                                                 8191};
  localparam int RANDOM_SET = 7;

  localparam logic [FRAME_W-1:0] SWEEP_FRAMES [16] = '{
    16'h8000, 16'h7FFF, 16'hFFFF, 16'd0, 16'd1, 16'd169, 16'd170, -16'sd170,
    -16'sd171, 16'd340, 16'd12345, -16'sd12345, 16'd2, -16'sd2, 16'd85, 16'd171
  };

  typedef struct packed {
    logic [MASK_W-1:0]  mask;
    logic [FRAME_W-1:0] frame;
  } tile_item_t;

  typedef struct packed {
    logic [QTR_W-1:0]   qi;
    logic [SRC_X_W-1:0] sx;
    logic [SRC_Y_W-1:0] sy;
    logic               last;
  } quarter_t;

  logic                       clk_i;
  logic                       rst_ni = 1'b0;
  logic                       cfg_we_i = 1'b0;
  logic [0:0]                 cfg_index_i = '0;
  logic [SHEET_W-1:0]         cfg_data_i = '0;
  logic                       item_valid_i = 1'b0;
  logic                       item_ready_o;
  logic [MASK_W-1:0]          neighbour_mask_i = '0;
  logic signed [FRAME_W-1:0]  frame_number_i = '0;
  logic                       result_valid_o;
  logic                       result_ready_i = 1'b0;
  logic [QTR_W-1:0]           quarter_index_o;
  logic [SRC_X_W-1:0]         source_x_o;
  logic [SRC_Y_W-1:0]         source_y_o;
  logic                       last_quarter_o;

  tile_item_t  queued_tiles[$];
  quarter_t    due_quarters[$];
  tile_item_t  next_tile;
  quarter_t    due;

  int unsigned tile_size_q   = TILE_SIZE_RESET;
  int unsigned sheet_width_q = SHEET_WIDTH_RESET;
  int          send_idle_pct = 18;
  int          recv_idle_pct = 70;
  int          tiles_sent;
  int          quarters_checked;
  int          mismatch_count;
  int          settings_used;
  int          quiet_cycles;

  autotile_quarter_source_select uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .item_valid_i     (item_valid_i),
    .item_ready_o     (item_ready_o),
    .neighbour_mask_i (neighbour_mask_i),
    .frame_number_i   (frame_number_i),
    .result_valid_o   (result_valid_o),
    .result_ready_i   (result_ready_i),
    .quarter_index_o  (quarter_index_o),
    .source_x_o       (source_x_o),
    .source_y_o       (source_y_o),
    .last_quarter_o   (last_quarter_o)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  function automatic int unsigned frame_count(input int unsigned tile, input int unsigned sheet);
    int unsigned n;
    if (tile == 0 || sheet == 0) begin
      return 1;
    end
    n = sheet / (3 * tile);
    return (n < 1) ? 1 : n;
  endfunction

  function automatic void predict_quarters(input logic [MASK_W-1:0] raw,
                                           input logic [FRAME_W-1:0] fbits);
    logic [MASK_W-1:0] kept;
    int                frames;
    int                fmod;
    int unsigned       cell_no;
    int unsigned       c0;
    int unsigned       half;
    int unsigned       xoff;
    int unsigned       sx;
    int unsigned       sy;
    quarter_t          r;
    kept = raw & 8'h0F;
    for (int q = 0; q < 4; q++) begin
      if (raw[SIDE_A_BIT[q]] && raw[SIDE_B_BIT[q]] && raw[DIAG_BIT[q]]) begin
        kept[DIAG_BIT[q]] = 1'b1;
      end
    end
    frames = frame_count(tile_size_q, sheet_width_q);
    // wrap negative frames into 0 .. frames-1
    fmod = ((int'($signed(fbits)) % frames) + frames) % frames;
    half = tile_size_q / 2;
    xoff = fmod * 3 * tile_size_q;
    for (int q = 0; q < 4; q++) begin
      cell_no = QUAD_CELLS[kept[3:0]][q];
      if (kept[SIDE_A_BIT[q]] && kept[SIDE_B_BIT[q]] && !kept[DIAG_BIT[q]]) begin
        cell_no = INNER_CELL;
      end
      c0 = cell_no - 1;
      sx = (c0 % 3) * tile_size_q + (q % 2) * half + xoff;
      sy = (c0 / 3) * tile_size_q + (q / 2) * half;
      r.qi   = q[QTR_W-1:0];
      r.sx   = sx[SRC_X_W-1:0];
      r.sy   = sy[SRC_Y_W-1:0];
      r.last = (q == 3);
      due_quarters.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: got %0d, want %0d (result %0d, t=%0t)", what, got, want,
               quarters_checked, $realtime);
    end
  endtask

  task automatic write_register(input cfg_reg_e idx, input logic [SHEET_W-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_TILE_SIZE) begin
      tile_size_q = data[TILE_W-1:0];
    end else begin
      sheet_width_q = data;
    end
    // hold until the frame count divide has finished
    @(posedge clk_i);
    while (!item_ready_o) @(posedge clk_i);
  endtask

  task automatic drain;
    while (queued_tiles.size() != 0 || item_valid_i || due_quarters.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Driver: present the next queued tile once the current one has gone
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_i     <= 1'b0;
      neighbour_mask_i <= '0;
      frame_number_i   <= '0;
    end else begin
      if (item_valid_i && item_ready_o) begin
        predict_quarters(neighbour_mask_i, frame_number_i);
        tiles_sent++;
      end
      if (!item_valid_i || item_ready_o) begin
        if (queued_tiles.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_tile = queued_tiles.pop_front();
          item_valid_i     <= 1'b1;
          neighbour_mask_i <= next_tile.mask;
          frame_number_i   <= next_tile.frame;
        end else begin
          item_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result transaction with the oldest due quarter
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_ready_i <= 1'b0;
    end else begin
      if (result_valid_o && result_ready_i) begin
        if (due_quarters.size() == 0) begin
          report_mismatch("result with nothing due, quarter", quarter_index_o, -1);
        end else begin
          due = due_quarters.pop_front();
          if (quarter_index_o !== due.qi) begin
            report_mismatch("quarter_index", quarter_index_o, due.qi);
          end
          if (source_x_o !== due.sx) begin
            report_mismatch("source_x", source_x_o, due.sx);
          end
          if (source_y_o !== due.sy) begin
            report_mismatch("source_y", source_y_o, due.sy);
          end
          if (last_quarter_o !== due.last) begin
            report_mismatch("last_quarter", last_quarter_o, due.last);
          end
        end
        quarters_checked++;
      end
      result_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up when nothing moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (item_valid_i && item_ready_o) || (result_valid_o && result_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    tile_item_t  t;
    int unsigned tile;
    int unsigned sheet;
    int unsigned frames;
    int          f;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < PHASES; p++) begin
      if (p < 4) begin
        send_idle_pct = 18;
        recv_idle_pct = 70;
      end else if (p < 7) begin
        send_idle_pct = 70;
        recv_idle_pct = 18;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end

      // the first set runs on the reset values
      if (p != 0) begin
        tile  = (p == RANDOM_SET) ? $urandom_range(255) : SET_TILE[p];
        sheet = (p == RANDOM_SET) ? $urandom_range(8191) : SET_SHEET[p];
        // upper data bits are ignored by the tile size register
        write_register(REG_TILE_SIZE, {5'($urandom_range(31)), tile[TILE_W-1:0]});
        write_register(REG_SHEET_WIDTH, sheet[SHEET_W-1:0]);
      end
      settings_used++;
      frames = frame_count(tile_size_q, sheet_width_q);

      if (p == 0) begin
        queued_tiles.push_back('{8'hFF, 16'd0});
        queued_tiles.push_back('{8'h0F, 16'd1});
        queued_tiles.push_back('{8'h00, 16'hFFFF});
        queued_tiles.push_back('{8'hAA, 16'h7FFF});
      end else if (p == 1) begin
        // every edge pattern with all diagonals offered, then the corner cases
        for (int e = 0; e < 16; e++) begin
          t.mask  = {4'hF, e[3:0]};
          t.frame = SWEEP_FRAMES[e];
          queued_tiles.push_back(t);
        end
        queued_tiles.push_back('{8'h0F, 16'd0});
        queued_tiles.push_back('{8'h1F, 16'hFFFF});
        queued_tiles.push_back('{8'hEF, 16'd3});
        queued_tiles.push_back('{8'h00, 16'h8000});
      end else begin
        for (int i = 0; i < RANDOM_PER_SET; i++) begin
          case ($urandom_range(3))
            0: t.mask = {4'($urandom_range(15)), 4'hF};
            1: t.mask = {4'hF, 4'($urandom_range(15))};
            default: t.mask = 8'($urandom_range(255));
          endcase
          case ($urandom_range(3))
            0: f = $urandom_range(65535);
            1: f = int'($urandom_range(2 * frames)) - int'(frames);
            2: f = $urandom_range(1) ? -32768 : 32767;
            default: f = int'(frames) * (int'($urandom_range(20)) - 10)
                         + int'($urandom_range(2)) - 1;
          endcase
          t.frame = f[FRAME_W-1:0];
          queued_tiles.push_back(t);
        end
      end
      // pause the sender until every due quarter has come back
      drain();
    end

    repeat (20) @(posedge clk_i);
    $display("covered %0d tiles and %0d quarter results over %0d register settings,",
             tiles_sent, quarters_checked, settings_used);
    $display("including zero, oversized and maximum sizes and both idle patterns");
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
